@@ rtl/ata_pkg.sv @@
// Package: shared constants, types and arctangent table for the tilt angle unit.
package ata_pkg;

	localparam int IterCount = 20;
	localparam int SqW       = 32;             // a^2 + b^2 reaches 2^31 at full scale
	localparam int RadW      = SqW + 16;       // radicand: sum << 16
	localparam int RootW     = 24;             // floor(sqrt(sum << 16)) < 2^24
	localparam int MagW      = 25;             // cordic operand width
	localparam int CxW       = 27;             // x grows by about 1.65
	localparam int CyW       = 27;
	localparam int CzW       = 27;             // signed angle accumulator
	localparam int AngW      = 15;
	localparam int RootSteps = 24;
	localparam int PayW      = 3 * 17;         // sign and magnitude of each axis
	localparam logic [CzW-1:0] ZMax = CzW'(9000 * 4096);
	localparam logic [13:0]    RightAngle = 14'd9000;

	typedef logic signed [15:0] sample_t;
	typedef logic signed [AngW-1:0] angle_t;

	// one cordic job: numerator, denominator, sign of the result
	typedef struct packed {
		logic [MagW-1:0] num;
		logic [MagW-1:0] den;
		logic            neg;
	} job_t;

	function automatic logic [CzW-1:0] atan_entry(input logic [4:0] i);
		logic [CzW-1:0] r;
		case (i)
			5'd0:  r = CzW'(18432000);
			5'd1:  r = CzW'(10881045);
			5'd2:  r = CzW'(5749245);
			5'd3:  r = CzW'(2918407);
			5'd4:  r = CzW'(1464867);
			5'd5:  r = CzW'(733147);
			5'd6:  r = CzW'(366663);
			5'd7:  r = CzW'(183343);
			5'd8:  r = CzW'(91673);
			5'd9:  r = CzW'(45837);
			5'd10: r = CzW'(22918);
			5'd11: r = CzW'(11459);
			5'd12: r = CzW'(5730);
			5'd13: r = CzW'(2865);
			5'd14: r = CzW'(1432);
			5'd15: r = CzW'(716);
			5'd16: r = CzW'(358);
			5'd17: r = CzW'(179);
			5'd18: r = CzW'(90);
			5'd19: r = CzW'(45);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/ata_if.sv @@
// Interfaces: sample request channel and angle result channel.
interface ata_sample_if;
	logic              valid;
	logic              ready;
	ata_pkg::sample_t  accel_x;
	ata_pkg::sample_t  accel_y;
	ata_pkg::sample_t  accel_z;
	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface ata_angle_if;
	logic             valid;
	logic             ready;
	ata_pkg::angle_t  angle_x;
	ata_pkg::angle_t  angle_y;
	ata_pkg::angle_t  angle_z;
	modport source (output valid, angle_x, angle_y, angle_z, input ready);
	modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

@@ rtl/ata_root_pipe.sv @@
// Pipelined integer square root: one result bit per stage, payload carried alongside.
module ata_root_pipe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [ata_pkg::SqW-1:0]   in_sq,
	input  logic [ata_pkg::PayW-1:0]  in_pay,
	output logic                      out_valid,
	output logic [ata_pkg::RootW-1:0] out_root,
	output logic [ata_pkg::PayW-1:0]  out_pay
);
	localparam int N  = ata_pkg::RootSteps;
	localparam int RW = ata_pkg::RadW + 1;

	logic [RW-1:0]            rem_s  [N+1];
	logic [N-1:0]             res_s  [N+1];
	logic [ata_pkg::PayW-1:0] pay_s  [N+1];
	logic                     vld_s  [N+1];

	always_comb begin
		rem_s[0] = RW'({in_sq, 16'd0});
		res_s[0] = '0;
		pay_s[0] = in_pay;
		vld_s[0] = in_valid;
	end

	// restoring root, one bit per stage from the top
	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int B = N - 1 - k;
		logic [RW-1:0] trial;
		logic [RW-1:0] rem_nx;
		logic [N-1:0]  res_nx;
		always_comb begin
			trial  = (RW'(res_s[k]) << (B + 1)) | (RW'(1) << (2 * B));
			rem_nx = rem_s[k];
			res_nx = res_s[k];
			if (rem_s[k] >= trial) begin
				rem_nx = rem_s[k] - trial;
				res_nx = res_s[k] | (N'(1) << B);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_nx;
				res_s[k+1] <= res_nx;
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = res_s[N];
	assign out_pay   = pay_s[N];
endmodule

@@ rtl/ata_cordic_pipe.sv @@
// Pipelined vectoring CORDIC: one micro-rotation per stage, ends in rounding and sign.
module ata_cordic_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  ata_pkg::job_t   in_job,
	output logic            out_valid,
	output ata_pkg::angle_t out_angle
);
	localparam int N = ata_pkg::IterCount;

	// carry the zero numerator and zero denominator flags with the data
	logic signed [ata_pkg::CxW-1:0] x_s  [N+1];
	logic signed [ata_pkg::CyW-1:0] y_s  [N+1];
	logic signed [ata_pkg::CzW-1:0] z_s  [N+1];
	logic                           ng_s [N+1];
	logic                           zn_s [N+1];
	logic                           zd_s [N+1];
	logic                           vl_s [N+1];
	logic                           vld_s1;
	ata_pkg::angle_t                ang_s1;

	always_comb begin
		x_s[0]  = ata_pkg::CxW'(in_job.den);
		y_s[0]  = ata_pkg::CyW'(in_job.num);
		z_s[0]  = '0;
		ng_s[0] = in_job.neg;
		zn_s[0] = (in_job.num == '0);
		zd_s[0] = (in_job.den == '0);
		vl_s[0] = in_valid;
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [ata_pkg::CxW-1:0] xn;
		logic signed [ata_pkg::CyW-1:0] yn;
		logic signed [ata_pkg::CzW-1:0] zn;
		always_comb begin
			if (!y_s[i][ata_pkg::CyW-1]) begin
				xn = x_s[i] + (y_s[i] >>> i);
				yn = y_s[i] - (x_s[i] >>> i);
				zn = z_s[i] + $signed(ata_pkg::atan_entry(5'(i)));
			end else begin
				xn = x_s[i] - (y_s[i] >>> i);
				yn = y_s[i] + (x_s[i] >>> i);
				zn = z_s[i] - $signed(ata_pkg::atan_entry(5'(i)));
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s[i+1] <= 1'b0;
			end else if (en) begin
				vl_s[i+1] <= vl_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]  <= xn;
				y_s[i+1]  <= yn;
				z_s[i+1]  <= zn;
				ng_s[i+1] <= ng_s[i];
				zn_s[i+1] <= zn_s[i];
				zd_s[i+1] <= zd_s[i];
			end
		end
	end

	logic [ata_pkg::CzW-1:0] zc;
	logic [ata_pkg::CzW-1:0] zr;
	logic [13:0]             mag;
	always_comb begin
		zc = z_s[N][ata_pkg::CzW-1] ? '0 : ata_pkg::CzW'(z_s[N]);
		if (zc > ata_pkg::ZMax) begin
			zc = ata_pkg::ZMax;
		end
		zr  = zc + ata_pkg::CzW'(2048);
		mag = zr[25:12];
		if (zn_s[N]) begin
			mag = '0;
		end else if (zd_s[N]) begin
			mag = ata_pkg::RightAngle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vl_s[N];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ng_s[N] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign out_valid = vld_s1;
	assign out_angle = ang_s1;
endmodule

@@ rtl/accel_tilt_angles_unit.sv @@
// Top level: tilt angles from one accelerometer sample, fully pipelined.
//  channel | dir | fields                          | handshake
//  in_ch   | in  | accel_x, accel_y, accel_z (s16) | valid/ready
//  out_ch  | out | angle_x, angle_y, angle_z (s15) | valid/ready
// Pipeline: squares, then the root (one bit a stage), then CORDIC and round.
// One sample is accepted each cycle while the pipe advances, which it does whenever the
// output register is empty or taken. Reset clears all valid bits; a stall holds every stage.
module accel_tilt_angles_unit (
	input logic        clk,
	input logic        arst_n,
	ata_sample_if.sink in_ch,
	ata_angle_if.source out_ch
);
	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: register magnitudes and signs
	logic        vld_s1, vld_s2;
	logic [15:0] mx_s1, my_s1, mz_s1;
	logic        nx_s1, ny_s1, nz_s1;
	logic [ata_pkg::SqW-1:0]  sx_s2, sy_s2, sz_s2;
	logic [ata_pkg::PayW-1:0] pay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= in_ch.accel_x[15] ? 16'(-in_ch.accel_x) : 16'(in_ch.accel_x);
			my_s1 <= in_ch.accel_y[15] ? 16'(-in_ch.accel_y) : 16'(in_ch.accel_y);
			mz_s1 <= in_ch.accel_z[15] ? 16'(-in_ch.accel_z) : 16'(in_ch.accel_z);
			nx_s1 <= in_ch.accel_x[15];
			ny_s1 <= in_ch.accel_y[15];
			nz_s1 <= in_ch.accel_z[15];
			// stage 2: pair sums of squares
			sx_s2  <= ata_pkg::SqW'(32'(my_s1) * 32'(my_s1) + 32'(mz_s1) * 32'(mz_s1));
			sy_s2  <= ata_pkg::SqW'(32'(mx_s1) * 32'(mx_s1) + 32'(mz_s1) * 32'(mz_s1));
			sz_s2  <= ata_pkg::SqW'(32'(mx_s1) * 32'(mx_s1) + 32'(my_s1) * 32'(my_s1));
			pay_s2 <= {nx_s1, mx_s1, ny_s1, my_s1, nz_s1, mz_s1};
		end
	end

	logic                      rv [3];
	logic [ata_pkg::RootW-1:0] rr [3];
	logic [ata_pkg::PayW-1:0]  rp [3];
	logic [ata_pkg::SqW-1:0]   sq [3];
	assign sq[0] = sx_s2;
	assign sq[1] = sy_s2;
	assign sq[2] = sz_s2;

	for (genvar a = 0; a < 3; a++) begin : g_root
		ata_root_pipe u_root (
			.clk, .arst_n, .en,
			.in_valid (vld_s2),
			.in_sq    (sq[a]),
			.in_pay   (pay_s2),
			.out_valid(rv[a]),
			.out_root (rr[a]),
			.out_pay  (rp[a])
		);
	end

	ata_pkg::job_t   job [3];
	logic            cv  [3];
	ata_pkg::angle_t ca  [3];
	always_comb begin
		job[0].num = ata_pkg::MagW'({rp[0][49:34], 8'd0});
		job[0].den = ata_pkg::MagW'(rr[0]);
		job[0].neg = rp[0][50];
		job[1].num = ata_pkg::MagW'({rp[1][32:17], 8'd0});
		job[1].den = ata_pkg::MagW'(rr[1]);
		job[1].neg = rp[1][33];
		job[2].num = ata_pkg::MagW'(rr[2]);
		job[2].den = ata_pkg::MagW'({rp[2][15:0], 8'd0});
		job[2].neg = rp[2][16];
	end

	for (genvar a = 0; a < 3; a++) begin : g_cordic
		ata_cordic_pipe u_cordic (
			.clk, .arst_n, .en,
			.in_valid (rv[a]),
			.in_job   (job[a]),
			.out_valid(cv[a]),
			.out_angle(ca[a])
		);
	end

	assign out_ch.valid   = cv[0];
	assign out_ch.angle_x = ca[0];
	assign out_ch.angle_y = ca[1];
	assign out_ch.angle_z = ca[2];

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(cv[0] == cv[1]) && (cv[0] == cv[2]))
		else $error("lane valid bits diverged");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.angle_z))
		else $error("result changed under stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.angle_x <= 15'sd9000) && (out_ch.angle_x >= -15'sd9000))
		else $error("angle out of range");
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for the tilt angle unit: directed table, random samples, angle predictor.
module testbench;

	localparam int Latency = 47;
	localparam int IdleLimit = 20000;
	localparam int RandCount = 600;

	typedef struct packed {
		ata_pkg::angle_t ax;
		ata_pkg::angle_t ay;
		ata_pkg::angle_t az;
	} angles_t;

	typedef struct {
		ata_pkg::sample_t x;
		ata_pkg::sample_t y;
		ata_pkg::sample_t z;
		bit               known;
		angles_t          ang;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ata_sample_if in_ch();
	ata_angle_if  out_ch();

	accel_tilt_angles_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	angles_t angle_queue[$];
	int mismatches = 0;
	int n_checked = 0;
	int n_sent = 0;
	int idle_cycles = 0;
	bit quiet_rx = 0;
	bit hold_rx = 0;

	// magnitude path: table value of atan(2^-i), units of 1/409600 degree
	function automatic longint atan_step(int i);
		longint t[20] = '{18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663,
			183343, 91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
		return t[i];
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 48;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint tilt_mag(longint num, longint den);
		longint x, y, z, xs, ys;
		x = den;
		y = num;
		z = 0;
		if (num == 0) return 0;
		if (den == 0) return 9000;
		for (int i = 0; i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += atan_step(i);
			end else begin
				x -= ys;
				y += xs;
				z -= atan_step(i);
			end
		end
		if (z < 0) z = 0;
		if (z > 64'sd9000 * 4096) z = 64'sd9000 * 4096;
		return (z + 2048) >>> 12;
	endfunction

	function automatic angles_t tilt_angles(ata_pkg::sample_t sx, ata_pkg::sample_t sy,
			ata_pkg::sample_t sz);
		longint a, b, c, r;
		angles_t res;
		a = sx;
		b = sy;
		c = sz;
		r = tilt_mag((a < 0 ? -a : a) << 8, isqrt((b * b + c * c) << 16));
		res.ax = ata_pkg::angle_t'(a < 0 ? -r : r);
		r = tilt_mag((b < 0 ? -b : b) << 8, isqrt((a * a + c * c) << 16));
		res.ay = ata_pkg::angle_t'(b < 0 ? -r : r);
		r = tilt_mag(isqrt((a * a + b * b) << 16), (c < 0 ? -c : c) << 8);
		res.az = ata_pkg::angle_t'(c < 0 ? -r : r);
		return res;
	endfunction

	function automatic row_t mk(int x, int y, int z, bit known = 0,
			int ex = 0, int ey = 0, int ez = 0);
		row_t r;
		r.x = ata_pkg::sample_t'(x);
		r.y = ata_pkg::sample_t'(y);
		r.z = ata_pkg::sample_t'(z);
		r.known = known;
		r.ang = '{ata_pkg::angle_t'(ex), ata_pkg::angle_t'(ey), ata_pkg::angle_t'(ez)};
		return r;
	endfunction

	function automatic ata_pkg::sample_t rand_axis();
		case ($urandom_range(0, 9))
			0: return ata_pkg::sample_t'($urandom_range(0, 3) == 0 ? 0 : 16'h8000);
			1: return ata_pkg::sample_t'($urandom_range(0, 1) ? 16'h7fff : 16'h0001);
			2: return ata_pkg::sample_t'(int'($urandom_range(0, 8)) - 4);
			default: return ata_pkg::sample_t'($urandom);
		endcase
	endfunction

	// one request, with random idling unless the stretch says otherwise
	task automatic send_sample(row_t r, bit busy_only);
		angles_t e;
		if (!busy_only && $urandom_range(0, 99) < 8) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.accel_x <= r.x;
		in_ch.accel_y <= r.y;
		in_ch.accel_z <= r.z;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		e = r.known ? r.ang : tilt_angles(r.x, r.y, r.z);
		if (r.known && e != tilt_angles(r.x, r.y, r.z))
			$display("note: table row %0d/%0d/%0d disagrees with predictor", r.x, r.y, r.z);
		angle_queue.push_back(e);
		n_sent++;
	endtask

	// receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !hold_rx && (quiet_rx || $urandom_range(0, 99) >= 8);
			if (out_ch.valid && out_ch.ready) begin
				if (angle_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
						out_ch.angle_x, out_ch.angle_y, out_ch.angle_z);
				end else begin
					angles_t e;
					e = angle_queue.pop_front();
					n_checked++;
					if (e.ax !== out_ch.angle_x || e.ay !== out_ch.angle_y ||
							e.az !== out_ch.angle_z) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
								e.ax, e.ay, e.az, out_ch.angle_x, out_ch.angle_y,
								out_ch.angle_z);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout after %0d quiet cycles", idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	initial begin
		wait (n_sent >= 150);
		hold_rx = 1'b1;
		repeat (200) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		row_t table_rows[$];
		in_ch.valid = 1'b0;
		in_ch.accel_x = '0;
		in_ch.accel_y = '0;
		in_ch.accel_z = '0;
		table_rows = '{
			mk(0, 0, 0, 1, 0, 0, 0),
			mk(0, 0, 1000, 1, 0, 0, 0),
			mk(0, 0, -1000, 1, 0, 0, 0),
			mk(1000, 0, 0, 1, 9000, 0, 9000),
			mk(-1000, 0, 0, 1, -9000, 0, 9000),
			mk(0, 1000, 0, 1, 0, 9000, 9000),
			mk(0, -1000, 0, 1, 0, -9000, 9000),
			mk(32767, 0, 0, 1, 9000, 0, 9000),
			mk(-32768, 0, 0, 1, -9000, 0, 9000),
			mk(0, -32768, 0, 1, 0, -9000, 9000),
			mk(0, 0, -32768, 1, 0, 0, 0),
			mk(0, 0, 32767, 1, 0, 0, 0),
			mk(1000, 0, 1000),
			mk(-1000, 1000, -1000),
			mk(-32768, -32768, -32768),
			mk(32767, 32767, 32767),
			mk(-32768, 32767, -32768),
			mk(1, 0, 0),
			mk(1, 1, 1),
			mk(-1, -1, -1),
			mk(1, 0, -32768),
			mk(0, 16384, 16384),
			mk(-21845, 10922, 5461)
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i]) send_sample(table_rows[i], 0);
		for (int i = 0; i < RandCount; i++) begin
			// quiet stretch on both sides
			quiet_rx = (i >= 400 && i < 500);
			if (i == 300) begin
				in_ch.valid <= 1'b0;
				wait (angle_queue.size() == 0);
				@(posedge clk);
			end
			send_sample(mk(rand_axis(), rand_axis(), rand_axis()), quiet_rx);
		end
		in_ch.valid <= 1'b0;
		wait (angle_queue.size() == 0);
		repeat (Latency + 10) @(posedge clk);
		$display("sent %0d samples (directed axes, extremes, zero cases, random),", n_sent);
		$display("checked %0d angle results, %0d mismatches", n_checked, mismatches);
		if (mismatches == 0 && angle_queue.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
